// ----- src/whpd_pkg.sv -----
// ----------------------------------------------------------------------------
// whpd_pkg
// Shared types for the warehouse placement hull block.
// ----------------------------------------------------------------------------
package whpd_pkg;

  // Request to the shared multiplier.
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  // Result from the shared multiplier.
  typedef struct packed {
    logic         done;
    logic [127:0] prod;
  } mul_rsp_t;

endpackage

// ----- src/whpd_ram.sv -----
// ----------------------------------------------------------------------------
// whpd_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module whpd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- src/whpd_mul.sv -----
// ----------------------------------------------------------------------------
// whpd_mul
// Signed 64x64 to 128-bit multiplier built from one 32x32 unsigned multiplier
// that is used four times, followed by two sign correction steps.
// ----------------------------------------------------------------------------
module whpd_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  whpd_pkg::mul_req_t  req_i,
  output whpd_pkg::mul_rsp_t  rsp_o
);
  import whpd_pkg::*;

  logic [63:0]  a_q, b_q;
  logic [127:0] acc_q;
  logic [63:0]  prod_q;
  logic [6:0]   sh_q;
  logic [2:0]   cnt_q;
  logic         run_q, done_q;
  logic [31:0]  a_sel, b_sel;

  assign a_sel = cnt_q[1] ? a_q[63:32] : a_q[31:0];
  assign b_sel = cnt_q[0] ? b_q[63:32] : b_q[31:0];

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd6) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Partial products are formed in steps 0..3 and summed in steps 1..4;
  // steps 5 and 6 turn the unsigned product into the signed one.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (run_q) begin
      if (cnt_q < 3'd4) begin
        prod_q <= 64'(a_sel * b_sel);
        sh_q   <= 7'({1'b0, cnt_q[1]} + {1'b0, cnt_q[0]}) << 5;
      end
      if (cnt_q >= 3'd1 && cnt_q <= 3'd4) begin
        acc_q <= acc_q + ({64'b0, prod_q} << sh_q);
      end else if (cnt_q == 3'd5 && a_q[63]) begin
        acc_q[127:64] <= acc_q[127:64] - b_q;
      end else if (cnt_q == 3'd6 && b_q[63]) begin
        acc_q[127:64] <= acc_q[127:64] - a_q;
      end
    end
  end

endmodule

// ----- src/warehouse_placement_hull_dp_top.sv -----
// ----------------------------------------------------------------------------
// warehouse_placement_hull_dp_top
// Least-cost warehouse placement by a convex hull trick over a ring of hull
// points, driven by a small sequencer around one shared multiplier.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                   | tlast     | tuser
//  s_axis   | in  | position, goods, build_cost (96 b)   | last_site | -
//  m_axis   | out | cost_here, best_total (128 b)        | final_res | hull_overflow
//
// An item runs a carry, a cost and a new-point multiply; each head compare adds
// one multiply and each tail compare two (each advance or pop, and the compare
// that ends a nonempty walk). The input is not ready while an item is being
// worked on. A finished result waits in the output register; the next item is
// taken once it is free or leaving. Reset and a transfer with last_site set
// return the hull to the origin point, with no memory sweep.
// ----------------------------------------------------------------------------
module warehouse_placement_hull_dp_top #(
  parameter int HULL_DEPTH = 65536
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // position, goods, build_cost, zero pad
  input  logic         s_axis_tlast,   // last_site
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // cost_here, best_total, zero pad
  output logic         m_axis_tlast,   // final_res
  output logic         m_axis_tuser    // hull_overflow
);
  import whpd_pkg::*;

  localparam int AW = (HULL_DEPTH > 1) ? $clog2(HULL_DEPTH) : 1;
  localparam logic [AW-1:0] IdxLast = AW'(HULL_DEPTH - 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CARRY = 10'b0000000010,
    S_HRD   = 10'b0000000100,
    S_HMUL  = 10'b0000001000,
    S_COST  = 10'b0000010000,
    S_CMUL  = 10'b0000100000,
    S_NMUL  = 10'b0001000000,
    S_TRD   = 10'b0010000000,
    S_TM    = 10'b0100000000,
    S_INS   = 10'b1000000000
  } state_e;

  function automatic logic [AW-1:0] ring_nxt(logic [AW-1:0] i);
    return (i == IdxLast) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_prv(logic [AW-1:0] i);
    return (i == '0) ? IdxLast : i - AW'(1);
  endfunction

  state_e state_q, state_d;
  logic [30:0] pos_q, pos_d, bc_q, bc_d, prev_q, prev_d;
  logic        last_q, last_d, gnz_q, gnz_d;
  logic [63:0] gp_q, gp_d, cpp_q, cpp_d, cost_q, cost_d, ny_q, ny_d;
  logic [63:0] best_q, best_d, dy_q, dy_d;
  logic [63:0] hs_q, hs_d, hi_q, hi_d, ts_q, ts_d, ti_q, ti_d, cs_q, cs_d, ci_q, ci_d;
  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic        orig_q, orig_d, ovf_q, ovf_d, pass2_q, pass2_d;
  logic [127:0] p1_q, p1_d;
  logic        ov_q, ov_d, ofin_q, ofin_d, oovf_q, oovf_d;
  logic [62:0] ocost_q, ocost_d, obest_q, obest_d;

  logic [63:0] xw;
  logic        re, we, rzero_q;
  logic [AW-1:0] raddr, waddr;
  logic [127:0] rdata, wdata;
  logic [63:0] rd_s, rd_i, newbest;
  mul_req_t    mreq;
  mul_rsp_t    mrsp;

  assign xw = {33'b0, pos_q};
  // Slot 0 holds the origin point until it is first written in this set.
  assign rd_s = rzero_q ? 64'b0 : rdata[127:64];
  assign rd_i = rzero_q ? 64'b0 : rdata[63:0];

  whpd_ram #(.Width(128), .Depth(HULL_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  whpd_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rsp_o  (mrsp)
  );

  assign s_axis_tready = (state_q == S_IDLE) && (!ov_q || m_axis_tready);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {2'b0, obest_q, ocost_q};
  assign m_axis_tlast  = ofin_q;
  assign m_axis_tuser  = oovf_q;

  always_comb begin
    state_d = state_q;
    pos_d = pos_q;  bc_d = bc_q;  prev_d = prev_q;  last_d = last_q;  gnz_d = gnz_q;
    gp_d = gp_q;  cpp_d = cpp_q;  cost_d = cost_q;  ny_d = ny_q;  best_d = best_q;
    dy_d = dy_q;  hs_d = hs_q;  hi_d = hi_q;  ts_d = ts_q;  ti_d = ti_q;
    cs_d = cs_q;  ci_d = ci_q;  head_d = head_q;  tail_d = tail_q;
    orig_d = orig_q;  ovf_d = ovf_q;  pass2_d = pass2_q;  p1_d = p1_q;
    ov_d = ov_q;  ofin_d = ofin_q;  oovf_d = oovf_q;  ocost_d = ocost_q;  obest_d = obest_q;
    mreq = '0;
    re = 1'b0;  raddr = '0;  we = 1'b0;  waddr = '0;  wdata = '0;
    newbest = best_q;

    if (ov_q && m_axis_tready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          pos_d  = s_axis_tdata[30:0];
          gnz_d  = s_axis_tdata[61:31] != 31'b0;
          gp_d   = gp_q + {33'b0, s_axis_tdata[61:31]};
          bc_d   = s_axis_tdata[92:62];
          last_d = s_axis_tlast;
          mreq.start = 1'b1;
          mreq.a = gp_q;
          mreq.b = {33'b0, s_axis_tdata[30:0]} - {33'b0, prev_q};
          state_d = S_CARRY;
        end
      end
      S_CARRY: begin
        if (mrsp.done) begin
          cpp_d  = cpp_q + mrsp.prod[63:0];
          prev_d = pos_q;
          if (head_q != tail_q) begin
            re = 1'b1;
            raddr = ring_nxt(head_q);
            state_d = S_HRD;
          end else begin
            state_d = S_COST;
          end
        end
      end
      S_HRD: begin
        cs_d = rd_s;
        ci_d = rd_i;
        dy_d = rd_i - hi_q;
        mreq.start = 1'b1;
        mreq.a = xw;
        mreq.b = rd_s - hs_q;
        state_d = S_HMUL;
      end
      S_HMUL: begin
        if (mrsp.done) begin
          if ($signed(mrsp.prod) >= $signed({{64{dy_q[63]}}, dy_q})) begin
            head_d = ring_nxt(head_q);
            hs_d = cs_q;
            hi_d = ci_q;
            if (ring_nxt(head_q) != tail_q) begin
              re = 1'b1;
              raddr = ring_nxt(ring_nxt(head_q));
              state_d = S_HRD;
            end else begin
              state_d = S_COST;
            end
          end else begin
            state_d = S_COST;
          end
        end
      end
      S_COST: begin
        mreq.start = 1'b1;
        mreq.a = xw;
        mreq.b = hs_q;
        state_d = S_CMUL;
      end
      S_CMUL: begin
        if (mrsp.done) begin
          cost_d = hi_q - mrsp.prod[63:0] + {33'b0, bc_q} + cpp_q;
          mreq.start = 1'b1;
          mreq.a = xw;
          mreq.b = gp_q;
          state_d = S_NMUL;
        end
      end
      S_NMUL: begin
        if (mrsp.done) begin
          ny_d = cost_q + mrsp.prod[63:0] - cpp_q;
          if (head_q != tail_q) begin
            re = 1'b1;
            raddr = ring_prv(tail_q);
            state_d = S_TRD;
          end else begin
            state_d = S_INS;
          end
        end
      end
      S_TRD: begin
        cs_d = rd_s;
        ci_d = rd_i;
        pass2_d = 1'b0;
        mreq.start = 1'b1;
        mreq.a = ny_q - rd_i;
        mreq.b = gp_q - ts_q;
        state_d = S_TM;
      end
      S_TM: begin
        if (mrsp.done && !pass2_q) begin
          p1_d = mrsp.prod;
          pass2_d = 1'b1;
          mreq.start = 1'b1;
          mreq.a = gp_q - cs_q;
          mreq.b = ny_q - ti_q;
        end else if (mrsp.done) begin
          // The tail point leaves when it no longer lies below the new segment.
          if ($signed(p1_q) >= $signed(mrsp.prod)) begin
            tail_d = ring_prv(tail_q);
            ts_d = cs_q;
            ti_d = ci_q;
            if (ring_prv(tail_q) != head_q) begin
              re = 1'b1;
              raddr = ring_prv(ring_prv(tail_q));
              state_d = S_TRD;
            end else begin
              state_d = S_INS;
            end
          end else begin
            state_d = S_INS;
          end
        end
      end
      S_INS: begin
        if (ring_nxt(tail_q) == head_q) begin
          ovf_d = 1'b1;
        end else begin
          we = 1'b1;
          waddr = ring_nxt(tail_q);
          wdata = {gp_q, ny_q};
          tail_d = ring_nxt(tail_q);
          ts_d = gp_q;
          ti_d = ny_q;
          if (ring_nxt(tail_q) == '0) begin
            orig_d = 1'b0;
          end
        end
        if (gnz_q || cost_q < best_q) begin
          newbest = cost_q;
        end
        best_d  = newbest;
        ov_d    = 1'b1;
        ocost_d = cost_q[63] ? {63{1'b1}} : cost_q[62:0];
        obest_d = newbest[63] ? {63{1'b1}} : newbest[62:0];
        ofin_d  = last_q;
        oovf_d  = ovf_d;
        if (last_q) begin
          gp_d = '0;  cpp_d = '0;  prev_d = '0;
          head_d = '0;  tail_d = '0;
          hs_d = '0;  hi_d = '0;  ts_d = '0;  ti_d = '0;
          orig_d = 1'b1;  ovf_d = 1'b0;
          best_d = 64'h8000_0000_0000_0000;
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      gp_q <= '0;  cpp_q <= '0;  prev_q <= '0;
      head_q <= '0;  tail_q <= '0;
      hs_q <= '0;  hi_q <= '0;  ts_q <= '0;  ti_q <= '0;
      orig_q <= 1'b1;  ovf_q <= 1'b0;  ov_q <= 1'b0;  pass2_q <= 1'b0;
      best_q <= 64'h8000_0000_0000_0000;
      rzero_q <= 1'b0;
    end else begin
      state_q <= state_d;
      gp_q <= gp_d;  cpp_q <= cpp_d;  prev_q <= prev_d;
      head_q <= head_d;  tail_q <= tail_d;
      hs_q <= hs_d;  hi_q <= hi_d;  ts_q <= ts_d;  ti_q <= ti_d;
      orig_q <= orig_d;  ovf_q <= ovf_d;  ov_q <= ov_d;  pass2_q <= pass2_d;
      best_q <= best_d;
      if (re) begin
        rzero_q <= orig_q && (raddr == '0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;  bc_q <= bc_d;  last_q <= last_d;  gnz_q <= gnz_d;
    cost_q <= cost_d;  ny_q <= ny_d;  dy_q <= dy_d;  cs_q <= cs_d;  ci_q <= ci_d;
    p1_q <= p1_d;  ofin_q <= ofin_d;  oovf_q <= oovf_d;
    ocost_q <= ocost_d;  obest_q <= obest_d;
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the warehouse placement hull block. A directed table
// and about 2000 random sites in sets of random length are streamed in. A
// built-in hull predictor works out every result. Each result is compared
// field by field under several idle and stall patterns on both streams.
// ----------------------------------------------------------------------------
module tb;

  // A small ring so that the hull-full case is reachable.
  localparam int HD = 4;
  localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;
  localparam logic [63:0] TOP = 64'h8000_0000_0000_0000;
  localparam int RAND_ITEMS = 2000;

  typedef struct {
    logic [30:0] pos;
    logic [30:0] goods;
    logic [30:0] bc;
    logic        last;
  } site_t;

  typedef struct {
    logic [62:0] cost;
    logic [62:0] best;
    logic        fin;
    logic        ovf;
  } res_t;

  typedef struct {
    site_t       s;
    bit          typed;
    logic [62:0] cost;
    logic [62:0] best;
  } row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata;   // position, goods, build_cost, zero pad
  logic         s_axis_tlast;   // last_site
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;   // cost_here, best_total, zero pad
  logic         m_axis_tlast;   // final_res
  logic         m_axis_tuser;   // hull_overflow

  warehouse_placement_hull_dp_top #(.HULL_DEPTH(HD)) DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser
  );

  // Predictor state.
  logic [63:0] goods_sum, carry_sum, prev_pos, running_best;
  logic [63:0] hull_x [HD];
  logic [63:0] hull_y [HD];
  int          hull_head, hull_tail;
  bit          ring_full_seen;

  res_t pending_results[$];
  row_t rows[$];
  int   errors = 0;
  int   results_seen = 0;
  int   sets_closed = 0;
  int   overflows_seen = 0;
  int   sender_idle_pct = 0;
  int   receiver_stall_pct = 0;

  function automatic void clear_hull();
    goods_sum = '0;
    carry_sum = '0;
    prev_pos = '0;
    hull_x[0] = '0;
    hull_y[0] = '0;
    hull_head = 0;
    hull_tail = 0;
    running_best = TOP;
    ring_full_seen = 0;
  endfunction

  function automatic void add_row(site_t s, bit typed, logic [62:0] cost,
                                  logic [62:0] best);
    row_t r;
    r.s = s;
    r.typed = typed;
    r.cost = cost;
    r.best = best;
    rows.insert(rows.size(), r);
  endfunction

  // Exact signed compare a*b >= c*d on 128-bit products.
  function automatic bit prod_ge(logic signed [63:0] a, logic signed [63:0] b,
                                 logic signed [63:0] c, logic signed [63:0] d);
    logic signed [127:0] l, r;
    l = a * b;
    r = c * d;
    return l >= r;
  endfunction

  function automatic res_t place_site(site_t s);
    logic [63:0] x, g, bc, carry, cost, nx, ny;
    int          nh, pv;
    res_t        r;
    x = {33'd0, s.pos};
    g = {33'd0, s.goods};
    bc = {33'd0, s.bc};
    carry = carry_sum + goods_sum * (x - prev_pos);
    carry_sum = carry;
    prev_pos = x;
    goods_sum = goods_sum + g;
    while (hull_head != hull_tail) begin
      nh = (hull_head + 1) % HD;
      if (!prod_ge(x, hull_x[nh] - hull_x[hull_head], 64'd1,
                   hull_y[nh] - hull_y[hull_head])) break;
      hull_head = nh;
    end
    cost = hull_y[hull_head] - x * hull_x[hull_head] + bc + carry;
    nx = goods_sum;
    ny = cost + x * goods_sum - carry;
    while (hull_head != hull_tail) begin
      pv = (hull_tail + HD - 1) % HD;
      if (!prod_ge(ny - hull_y[pv], nx - hull_x[hull_tail],
                   nx - hull_x[pv], ny - hull_y[hull_tail])) break;
      hull_tail = pv;
    end
    if ((hull_tail - hull_head + HD) % HD + 1 >= HD) begin
      ring_full_seen = 1;
    end else begin
      hull_tail = (hull_tail + 1) % HD;
      hull_x[hull_tail] = nx;
      hull_y[hull_tail] = ny;
    end
    if (g != 0) running_best = cost;
    else if (cost < running_best) running_best = cost;
    r.cost = cost[63] ? {63{1'b1}} : cost[62:0];
    r.best = running_best[63] ? {63{1'b1}} : running_best[62:0];
    r.fin = s.last;
    r.ovf = ring_full_seen;
    if (s.last) clear_hull();
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("Timeout at %0t", $time);
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver side: random stalls, changed at the falling edge.
  initial m_axis_tready = 1'b0;
  always @(negedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);

  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result tdata=%h", $time, m_axis_tdata);
      end else begin
        e = pending_results.pop_front();
        if (m_axis_tdata[62:0] !== e.cost) begin
          errors++;
          $display("%0t: cost_here exp %0d got %0d", $time, e.cost, m_axis_tdata[62:0]);
        end
        if (m_axis_tdata[125:63] !== e.best) begin
          errors++;
          $display("%0t: best_total exp %0d got %0d", $time, e.best,
                   m_axis_tdata[125:63]);
        end
        if (m_axis_tlast !== e.fin) begin
          errors++;
          $display("%0t: final_res exp %0b got %0b", $time, e.fin, m_axis_tlast);
        end
        if (m_axis_tuser !== e.ovf) begin
          errors++;
          $display("%0t: hull_overflow exp %0b got %0b", $time, e.ovf, m_axis_tuser);
        end
        if (e.fin) sets_closed++;
        if (e.fin && e.ovf) overflows_seen++;
      end
    end
  end

  // Drives one site from a falling edge and waits for its transfer, then files
  // its expectation. It returns at a falling edge with tvalid still high.
  task automatic send_site(site_t s, bit typed, logic [62:0] tcost, logic [62:0] tbest);
    res_t r;
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata <= {3'b000, s.bc, s.goods, s.pos};
    s_axis_tlast <= s.last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    r = place_site(s);
    if (typed) begin
      r.cost = tcost;
      r.best = tbest;
    end
    pending_results.insert(pending_results.size(), r);
    @(negedge clk_i);
  endtask

  // Called at a falling edge; returns at a falling edge with nothing pending.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    site_t s;
    int    sent, len, k;
    logic [30:0] pos;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    clear_hull();
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Single-site sets read off at a glance: the cost is just the build cost.
    add_row('{31'd0, 31'd0, 31'd5, 1'b1}, 1'b1, 63'd5, 63'd5);
    add_row('{MAX31, MAX31, MAX31, 1'b1}, 1'b1, 63'(MAX31), 63'(MAX31));
    add_row('{31'd0, 31'd0, 31'd0, 1'b1}, 1'b1, 63'd0, 63'd0);
    // Heavy goods carried over long distances wrap the cost; then a backward step.
    add_row('{31'd0, MAX31, 31'd0, 1'b0}, 1'b0, '0, '0);
    add_row('{MAX31, MAX31, 31'd0, 1'b0}, 1'b0, '0, '0);
    add_row('{MAX31, MAX31, MAX31, 1'b0}, 1'b0, '0, '0);
    add_row('{31'd0, MAX31, 31'd0, 1'b0}, 1'b0, '0, '0);
    add_row('{31'd100, 31'd0, 31'd7, 1'b1}, 1'b0, '0, '0);
    // Zero-goods tail sets keep a running minimum; growing hull fills the ring.
    for (k = 0; k < 10; k++)
      add_row('{31'(k * k * 10), 31'(k + 1), 31'(1000 - k * 90), 1'(k == 9)},
              1'b0, '0, '0);
    add_row('{31'd5, 31'd3, 31'd50, 1'b0}, 1'b0, '0, '0);
    add_row('{31'd9, 31'd0, 31'd1, 1'b0}, 1'b0, '0, '0);
    add_row('{31'd20, 31'd0, 31'd400, 1'b1}, 1'b0, '0, '0);
    foreach (rows[i]) send_site(rows[i].s, rows[i].typed, rows[i].cost, rows[i].best);
    drain();

    sent = 0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 84; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 84; end
        default: begin sender_idle_pct = 34; receiver_stall_pct = 34; end
      endcase
      while (sent < (phase + 1) * RAND_ITEMS / 4) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 15);
        pos = 31'($urandom_range(1000));
        for (k = 0; k < len; k++) begin
          if ($urandom_range(9) == 0) begin
            // Full-range fields, wrapping everything.
            s.pos = 31'($urandom);
            s.goods = 31'($urandom);
            s.bc = 31'($urandom);
          end else begin
            if ($urandom_range(49) == 0) pos = pos - 31'($urandom_range(500));
            else pos = pos + 31'($urandom_range(1000));
            s.pos = pos;
            s.goods = ($urandom_range(2) == 0) ? 31'd0 : 31'($urandom_range(2000));
            s.bc = 31'($urandom_range(200_000));
          end
          s.last = (k == len - 1);
          send_site(s, 1'b0, '0, '0);
          sent++;
        end
      end
      drain();
    end

    repeat (400) @(posedge clk_i);
    $display("Covered %0d directed and %0d random sites, %0d results in %0d sets,",
             rows.size(), sent, results_seen, sets_closed);
    $display("%0d sets with a full hull ring, under four idle and stall patterns.",
             overflows_seen);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/whpd_pkg.sv
src/whpd_ram.sv
src/whpd_mul.sv
src/warehouse_placement_hull_dp_top.sv
tb/tb.sv
